@@ hw/rtl/stream_pattern_replace_assert.svh @@
// Assertion macros for the stream pattern replace block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef STREAM_PATTERN_REPLACE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_pattern_replace assertion failed");

// Next-cycle implication, disabled during reset.
`define SPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_pattern_replace assertion failed");

`endif

@@ hw/rtl/spr_pkg.sv @@
// Package for the stream pattern replace block.
// Holds widths, register indexes and the byte type; no dependencies.
package spr_pkg;

    typedef logic [7:0] byte_t;

    localparam int LEN_W        = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

endpackage

@@ hw/rtl/stream_pattern_replace.sv @@
// Stream find-and-replace: rewrites a byte stream, replacing each pattern match.
// Uses spr_pkg and the assertion macros in stream_pattern_replace_assert.svh.
//
// Usage: bytes enter on the slave stream (s_tdata = in_byte, s_tlast ends a string)
// and leave on the master stream (m_tdata = out_byte, m_tuser = byte_valid; m_tlast
// ends the rewritten string). The pattern and the replacement are set through the
// write port (cfg_we, cfg_index, cfg_data) while the block is idle.
// An accepted word goes into an input register. Once the output buffer is empty, or
// its last word is being taken, the word is matched against the window and its
// results are loaded into the output buffer, whose first entry appears on the master
// side. While the receiver is ready, a word producing zero or one result keeps the
// rate at one word per cycle. A word producing k results (a replacement, a flush at
// the end of a string) holds the input while the buffer drains one word per cycle.
// A stalled receiver holds the buffer; the input register then fills and s_tready
// drops. Reset empties the window and the output buffer and clears all
// configuration registers, which leaves the block in pass-through mode.
module stream_pattern_replace
#(
    parameter int PATTERN_MAX = spr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = spr_pkg::REPLACE_MAX_DEF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                            m_tuser,   // [0] byte_valid
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import spr_pkg::*;

    localparam int OUT_D = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

    logic [CFG_DATA_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] repl_bytes_reg;
    logic [LEN_W-1:0]      repl_len_reg;

    logic                  in_valid_reg;
    byte_t                 in_byte_reg;
    logic                  in_last_reg;

    byte_t                 win_reg [PATTERN_MAX];
    logic [LEN_W-1:0]      fill_reg;

    byte_t                 obuf_reg [OUT_D];
    logic [LEN_W-1:0]      out_cnt_reg;
    logic                  out_bvalid_reg;
    logic                  out_last_reg;

    logic                  load_ok;
    logic                  proc;
    logic                  pop;

    logic [LEN_W-1:0]      fill1;
    logic [LEN_W-1:0]      plen;
    logic [LEN_W-1:0]      rlen;
    logic [LEN_W-1:0]      n_win;
    logic [LEN_W-1:0]      keep;
    logic [LEN_W-1:0]      n_out;
    logic                  match;
    logic                  use_repl;
    logic                  empty_end;
    byte_t                 w1 [PATTERN_MAX];
    byte_t                 wpad [OUT_D];
    byte_t                 win_shift [PATTERN_MAX];
    byte_t                 load_buf [OUT_D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg  <= '0;
            pat_len_reg    <= '0;
            repl_bytes_reg <= '0;
            repl_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:      pat_bytes_reg  <= cfg_data;
                REG_PATTERN_LENGTH:     pat_len_reg    <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  repl_bytes_reg <= cfg_data;
                REG_REPLACEMENT_LENGTH: repl_len_reg   <= cfg_data[LEN_W-1:0];
                default:                pat_len_reg    <= pat_len_reg;
            endcase
        end
    end

    assign load_ok  = (out_cnt_reg == '0) || ((out_cnt_reg == LEN_W'(1)) && m_tready);
    assign proc     = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || proc;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        fill1 = fill_reg + LEN_W'(1);
        plen  = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_reg;
        rlen  = (repl_len_reg > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : repl_len_reg;

        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            w1[i] = (LEN_W'(i) == fill_reg) ? in_byte_reg : win_reg[i];
        end

        match = (fill1 == plen);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((LEN_W'(i) < plen) && (w1[i] != pat_bytes_reg[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end

        use_repl = 1'b0;
        if (plen == '0)
        begin
            n_win = fill1;
        end
        else if (fill1 > plen)
        begin
            n_win = fill1 - plen + LEN_W'(1);
        end
        else if (fill1 == plen)
        begin
            if (match)
            begin
                use_repl = 1'b1;
                n_win    = '0;
            end
            else
            begin
                n_win = LEN_W'(1);
            end
        end
        else
        begin
            n_win = '0;
        end

        keep = use_repl ? '0 : (fill1 - n_win);

        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            win_shift[i] = w1[i];
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                if (LEN_W'(j) == (LEN_W'(i) + n_win))
                begin
                    win_shift[i] = w1[j];
                end
            end
        end

        if (in_last_reg)
        begin
            n_win = n_win + keep;
            keep  = '0;
        end

        n_out     = use_repl ? rlen : n_win;
        empty_end = in_last_reg && (n_out == '0);

        for (int i = 0; i < OUT_D; i++)
        begin
            wpad[i] = '0;
        end
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            wpad[i] = w1[i];
        end
        for (int i = 0; i < OUT_D; i++)
        begin
            load_buf[i] = use_repl ? repl_bytes_reg[8*i +: 8] : wpad[i];
        end

        if (empty_end)
        begin
            load_buf[0] = '0;
            n_out       = LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fill_reg     <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                fill_reg    <= keep;
                out_cnt_reg <= n_out;
            end
            else if (pop)
            begin
                out_cnt_reg <= out_cnt_reg - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end

        if (proc)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                win_reg[i] <= win_shift[i];
            end
            for (int i = 0; i < OUT_D; i++)
            begin
                obuf_reg[i] <= load_buf[i];
            end
            out_bvalid_reg <= !empty_end;
            out_last_reg   <= in_last_reg;
        end
        else if (pop)
        begin
            for (int i = 0; i < OUT_D - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
        end
    end

    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tdata  = obuf_reg[0];
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_last_reg && (out_cnt_reg == LEN_W'(1));

`include "stream_pattern_replace_assert.svh"

    `SPR_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg < LEN_W'(PATTERN_MAX))
    `SPR_ASSERT_NOW(a_out_bound, 1'b1, out_cnt_reg <= LEN_W'(OUT_D))
    `SPR_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, out_cnt_reg == $past(out_cnt_reg))
    `SPR_ASSERT_NEXT(a_last_flushes, proc && in_last_reg, fill_reg == '0 && m_tvalid)

endmodule
